// ===== rtl/i2a_pkg.sv =====
// shared constants, types and helpers for the integer to ascii formatter
package i2a_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * NIBBLE_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int unsigned ITER_W     = $clog2(VALUE_W);

  // format codes, the unused code prints as unsigned decimal
  localparam logic [MODE_W-1:0] FMT_UDEC = 2'd0;
  localparam logic [MODE_W-1:0] FMT_SDEC = 2'd1;
  localparam logic [MODE_W-1:0] FMT_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_EMIT
  } i2a_state_e;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [NIBBLE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > 4'd9) begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ===== rtl/i2a_dabble_step.sv =====
// one shift-and-add-3 step of the binary to bcd converter
module i2a_dabble_step
  import i2a_pkg::*;
(
  input  logic [BCD_W-1:0] bcd_i,
  input  logic             bit_i,
  output logic [BCD_W-1:0] bcd_o
);

  logic [BCD_W-1:0] adj;

  // digits are independent, correct each one before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd_i[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
      end else begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd_i[i*NIBBLE_W +: NIBBLE_W];
      end
    end
  end

  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level: sequencer, digit register and output register of the formatter
// sequence: accept, then the double dabble conversion for decimal and none for hex, then
//   leading-zero trimming, then one character a cycle while the output is not stalled
// flow: one number at a time, a new number is taken only after its last character is emitted;
//   decimal uses the single shared double dabble step that handles one input bit a cycle
// reset: asynchronous active low, returns to idle with the output register empty
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [MODE_W-1:0]   req_type_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CHAR_W-1:0]   out_char_o,
  output logic                last_o
);

  i2a_state_e state_q, state_d;

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_step;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic               pad_q, pad_d;
  logic               hex_q, hex_d;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic               in_acc;
  logic               slot_free;
  logic               emit;
  logic               is_last;
  logic               trim_more;
  logic               in_neg;
  logic [VALUE_W-1:0] in_mag;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = (state_q == ST_EMIT) && slot_free;
  assign is_last     = !neg_q && !pad_q && (cnt_q == CNT_W'(1));
  assign trim_more   = (bcd_q[BCD_W-1 -: NIBBLE_W] == '0) && (cnt_q > CNT_W'(1));
  assign in_neg      = (req_type_i == FMT_SDEC) && value_i[VALUE_W-1];
  assign in_mag      = in_neg ? (~value_i + VALUE_W'(1)) : value_i;

  i2a_dabble_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[VALUE_W-1]),
    .bcd_o (bcd_step)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (req_type_i == FMT_HEX) ? ST_TRIM : ST_CONV;
        end
      end
      ST_CONV: begin
        if (iter_q == ITER_W'(VALUE_W - 1)) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (!trim_more) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    pad_d       = pad_q;
    hex_d       = hex_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d  = in_neg;
          hex_d  = (req_type_i == FMT_HEX);
          pad_d  = 1'b0;
          iter_d = '0;
          cnt_d  = CNT_W'(NUM_DIGITS);
          bin_d  = in_mag;
          // hex digits are the nibbles themselves
          bcd_d  = (req_type_i == FMT_HEX) ? BCD_W'(in_mag) : '0;
        end
      end
      ST_CONV: begin
        bcd_d  = bcd_step;
        bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
        iter_d = iter_q + ITER_W'(1);
      end
      ST_TRIM: begin
        if (trim_more) begin
          bcd_d = {bcd_q[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          // hex with an odd digit count gets a leading zero
          pad_d = hex_q && cnt_q[0];
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          last_d      = is_last;
          priority if (neg_q) begin
            char_d = CHAR_MINUS;
            neg_d  = 1'b0;
          end else if (pad_q) begin
            char_d = CHAR_ZERO;
            pad_d  = 1'b0;
          end else begin
            char_d = digit_to_ascii(bcd_q[BCD_W-1 -: NIBBLE_W]);
            bcd_d  = {bcd_q[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      pad_q       <= 1'b0;
      hex_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      pad_q       <= pad_d;
      hex_q       <= hex_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CONV) || (state_q == ST_TRIM))
    else $error("accepted word did not start conversion");

  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("emitting with no digits left");

  a_conv_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) && (iter_q == ITER_W'(VALUE_W - 1)) |=> (state_q == ST_TRIM))
    else $error("conversion overran its bit count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (state_q == ST_IDLE) && out_valid_q && last_q)
    else $error("final character did not close the number");
`endif

endmodule

// ===== dv/i2a_checker.sv =====
// checker: predicts the character stream of each number and compares it with the block
`timescale 1ns / 100ps

module i2a_checker
  import i2a_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [MODE_W-1:0]  req_type_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CHAR_W-1:0]  out_char_i,
  input  logic               last_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_word_t;

  char_word_t expected_chars[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  // formats one number into the queue of expected characters
  function automatic void format_number(input logic [VALUE_W-1:0] v,
                                        input logic [MODE_W-1:0]  fmt);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    logic [VALUE_W-1:0] d;
    logic [CHAR_W-1:0]  text[$];
    logic               negative;
    char_word_t         w;

    negative = (fmt == FMT_SDEC) && v[VALUE_W-1];
    mag      = negative ? (~v + 1'b1) : v;
    radix    = (fmt == FMT_HEX) ? 64'd16 : 64'd10;
    do begin
      d = mag % radix;
      if (d > 9) begin
        text.push_front(CHAR_A + CHAR_W'(d - 10));
      end else begin
        text.push_front(CHAR_ZERO + CHAR_W'(d));
      end
      mag = mag / radix;
    end while (mag != 0);
    // hex always comes out in whole bytes
    if (fmt == FMT_HEX && text.size() % 2 == 1) begin
      text.push_front(CHAR_ZERO);
    end
    if (negative) begin
      text.push_front(CHAR_MINUS);
    end
    foreach (text[i]) begin
      w.code = text[i];
      w.last = (i == text.size() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t w;
    if (!rst_ni) begin
      pending_o <= 0;
    end else begin
      // check the output word first so a stray one cannot match a new number
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t checker: char %h last %b with no number pending",
                   $time, out_char_i, last_i);
          mismatches++;
        end else begin
          w = expected_chars.pop_front();
          if (out_char_i !== w.code || last_i !== w.last) begin
            $display("%0t checker: expected char %h last %b, got char %h last %b",
                     $time, w.code, w.last, out_char_i, last_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        format_number(value_i, req_type_i);
      end
      pending_o <= expected_chars.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, number stimulus, output back-pressure and verdict
`timescale 1ns / 100ps

module tb_top;
  import i2a_pkg::*;

  localparam logic [MODE_W-1:0] FMT_SPARE    = 2'd3;
  localparam int                RANDOM_ITEMS = 380;
  localparam int                HOLD_CYCLES  = 600;
  localparam int                TAIL_CYCLES  = 150;
  localparam int                CYCLE_LIMIT  = 1000000;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               num_valid = 1'b0;
  logic               num_ready;
  logic [VALUE_W-1:0] num_value = '0;
  logic [MODE_W-1:0]  num_fmt   = FMT_UDEC;
  logic               chr_valid;
  logic               chr_ready = 1'b0;
  logic [CHAR_W-1:0]  chr_code;
  logic               chr_last;

  int   pending;
  int   fail_count;
  int   cycles          = 0;
  int   sender_idle_pct = 12;
  int   recv_idle_pct   = 56;
  logic hold_wanted     = 1'b0;
  logic hold_taken      = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  integer_to_ascii_formatter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (num_valid),
    .in_ready_o (num_ready),
    .value_i    (num_value),
    .req_type_i (num_fmt),
    .out_valid_o(chr_valid),
    .out_ready_i(chr_ready),
    .out_char_o (chr_code),
    .last_o     (chr_last)
  );

  i2a_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_valid),
    .in_ready_i  (num_ready),
    .value_i     (num_value),
    .req_type_i  (num_fmt),
    .out_valid_i (chr_valid),
    .out_ready_i (chr_ready),
    .out_char_i  (chr_code),
    .last_i      (chr_last),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sink side: random back-pressure, plus one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        chr_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        chr_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_number(input logic [VALUE_W-1:0] v, input logic [MODE_W-1:0] fmt);
    while ($urandom_range(99) < sender_idle_pct) begin
      num_valid <= 1'b0;
      @(posedge clk_i);
    end
    num_valid <= 1'b1;
    num_value <= v;
    num_fmt   <= fmt;
    @(posedge clk_i);
    while (!num_ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    num_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = VALUE_W'($urandom_range(0, 999));
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: v = -VALUE_W'($urandom_range(1, 100000));
      4: begin
        // near a power of ten, where the digit count steps
        repeat ($urandom_range(19)) p = p * 10;
        v = p + VALUE_W'($urandom_range(2)) - 1'b1;
      end
      default: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(VALUE_W-1){1'b0}}};
          default: v = {1'b0, {(VALUE_W-1){1'b1}}};
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [MODE_W-1:0] pick_format();
    int r;
    r = $urandom_range(9);
    if (r < 3) return FMT_UDEC;
    if (r < 6) return FMT_SDEC;
    if (r < 9) return FMT_HEX;
    return FMT_SPARE;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of every format
    send_number('0, FMT_UDEC);
    send_number('0, FMT_SDEC);
    send_number('0, FMT_HEX);
    send_number('0, FMT_SPARE);
    send_number('1, FMT_UDEC);
    send_number('1, FMT_SDEC);
    send_number('1, FMT_HEX);
    send_number({1'b1, {(VALUE_W-1){1'b0}}}, FMT_SDEC);
    send_number({1'b1, {(VALUE_W-1){1'b0}}}, FMT_UDEC);
    send_number({1'b1, {(VALUE_W-1){1'b0}}}, FMT_HEX);
    send_number({1'b0, {(VALUE_W-1){1'b1}}}, FMT_SDEC);
    send_number(64'd1, FMT_HEX);
    send_number(64'h10, FMT_HEX);
    send_number(64'habcdef, FMT_HEX);
    send_number(64'h0123_4567_89ab_cdef, FMT_HEX);
    send_number(64'd9, FMT_UDEC);
    send_number(64'd10, FMT_SDEC);
    send_number(64'd10_000_000_000_000_000_000, FMT_UDEC);
    send_number(-64'd10, FMT_SDEC);
    send_number(64'd12345, FMT_SPARE);
    send_number({1'b1, {(VALUE_W-1){1'b0}}} | 64'd1, FMT_SPARE);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        sender_idle_pct <= 56;
        recv_idle_pct   <= 12;
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct <= 0;
        recv_idle_pct   <= 0;
      end
      if (n == 5 * RANDOM_ITEMS / 6) begin
        hold_wanted <= 1'b1;
      end
      send_number(pick_value(), pick_format());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2a_pkg.sv
rtl/i2a_dabble_step.sv
rtl/integer_to_ascii_formatter.sv
dv/i2a_checker.sv
dv/tb_top.sv
